// ----- rtl/core/fqs_pkg.sv -----
package fqs_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int POS_W  = 4;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;

   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic en;        // a word is accepted this cycle
      logic load;      // this cell takes the pushed word
      logic shift;     // pop: take the neighbor's word
      logic search;    // compare against the key
      logic occupied;  // cell holds a live entry
   } cell_ctrl_type;

endpackage

// ----- rtl/core/fqs_cell.sv -----
module fqs_cell (
   input  logic                                clock,
   input  fqs_pkg::cell_ctrl_type              ctrl,
   input  logic signed [fqs_pkg::WORD_W-1:0]   next_data,
   input  logic signed [fqs_pkg::WORD_W-1:0]   value,
   output logic signed [fqs_pkg::WORD_W-1:0]   data,
   output logic                                match
);
   import fqs_pkg::*;

   logic signed [WORD_W-1:0] data_ff;
   logic                     match_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         if (ctrl.load) begin
            data_ff <= value;
         end else if (ctrl.shift) begin
            data_ff <= next_data;
         end
         // compare sees the contents before this word's update
         match_ff <= ctrl.search & ctrl.occupied & (data_ff == value);
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

// ----- rtl/core/fqs_prienc.sv -----
module fqs_prienc (
   input  logic [fqs_pkg::DEPTH-1:0]  match,
   output logic [fqs_pkg::POS_W-1:0]  position,
   output logic                       found
);
   import fqs_pkg::*;

   always_comb begin
      position = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            position = POS_W'(i);
         end
      end
   end

   assign found = |match;

endmodule

// ----- rtl/core/fifo_queue_with_search_core.sv -----
// Bounded FIFO of signed 32-bit words with associative search.
// Request channel (req_*): kind selects push, pop or search; value is the
// word to push or the key. Response channel (rsp_*): one word per request,
// in order, carrying popped data, match position, found and status.
// Storage is a row of cells; cell 0 is always the head. A pop shifts every
// cell one step toward the head, a push loads the cell at the fill count,
// and a search compares the key in every cell at once.
// Response path: the cell compare and stage s1 are registered at the
// accepting edge, then the priority encode goes into the output register
// once that register is free. Throughput: one request per cycle while
// req_stall is low; the queue state is updated at the accepting edge, so
// back-to-back requests see each other's effect.
// A pop on an empty queue returns status empty, a push into a full queue
// returns status full; neither changes the state. Kind code 3 does nothing
// and returns all zeros.
// Reset (synchronous) empties the queue and drops any response in flight.
// While rsp_stall is high the response holds; the single stage behind it
// fills and then req_stall rises until the response is taken.
module fifo_queue_with_search_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fqs_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [fqs_pkg::WORD_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fqs_pkg::WORD_W-1:0]   rsp_data,
   output logic [fqs_pkg::POS_W-1:0]           rsp_position,
   output logic                                rsp_found,
   output logic [fqs_pkg::STAT_W-1:0]          rsp_status
);
   import fqs_pkg::*;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [WORD_W-1:0] s1_data_ff, s1_data_in;
   logic [STAT_W-1:0]        s1_status_ff, s1_status_in;
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_data_ff;
   logic [POS_W-1:0]         rsp_position_ff;
   logic                     rsp_found_ff;
   logic [STAT_W-1:0]        rsp_status_ff;

   logic                     acc, s1_go, push_ok, pop_ok, is_push, is_pop, is_search;
   logic signed [WORD_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]         match;
   logic [POS_W-1:0]         enc_position;
   logic                     enc_found;

   assign s1_go     = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_go;
   assign acc       = req_valid && !req_stall;

   assign is_push   = (req_kind == KIND_PUSH);
   assign is_pop    = (req_kind == KIND_POP);
   assign is_search = (req_kind == KIND_SEARCH);
   assign push_ok   = is_push && (count_ff != CNT_W'(DEPTH));
   assign pop_ok    = is_pop && (count_ff != '0);

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      cell_ctrl_type            ctrl;
      logic signed [WORD_W-1:0] nxt;

      assign ctrl.en       = acc;
      assign ctrl.load     = push_ok && (count_ff == CNT_W'(g));
      assign ctrl.shift    = pop_ok;
      assign ctrl.search   = is_search;
      assign ctrl.occupied = (CNT_W'(g) < count_ff);

      if (g == DEPTH - 1) begin : g_tail
         assign nxt = req_value;
      end else begin : g_mid
         assign nxt = cell_data[g+1];
      end

      fqs_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .next_data (nxt),
         .value     (req_value),
         .data      (cell_data[g]),
         .match     (match[g])
      );
   end

   fqs_prienc u_prienc (
      .match    (match),
      .position (enc_position),
      .found    (enc_found)
   );

   always_comb begin
      count_in     = count_ff;
      s1_data_in   = s1_data_ff;
      s1_status_in = s1_status_ff;
      s1_valid_in  = s1_go ? 1'b0 : s1_valid_ff;
      if (acc) begin
         s1_valid_in  = 1'b1;
         s1_data_in   = pop_ok ? cell_data[0] : '0;
         s1_status_in = STAT_OK;
         if (is_push && !push_ok) begin
            s1_status_in = STAT_FULL;
         end else if (is_pop && !pop_ok) begin
            s1_status_in = STAT_EMPTY;
         end
         if (push_ok) begin
            count_in = count_ff + CNT_W'(1);
         end else if (pop_ok) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff   <= s1_data_in;
      s1_status_ff <= s1_status_in;
      if (s1_go && s1_valid_ff) begin
         rsp_data_ff     <= s1_data_ff;
         rsp_status_ff   <= s1_status_ff;
         rsp_position_ff <= enc_position;
         rsp_found_ff    <= enc_found;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ----- rtl/core/fqs_checker.sv -----
module fqs_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [fqs_pkg::WORD_W-1:0]   rsp_data,
   input  logic [fqs_pkg::POS_W-1:0]           rsp_position,
   input  logic                                rsp_found,
   input  logic [fqs_pkg::STAT_W-1:0]          rsp_status
);
   import fqs_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status)
         && $stable(rsp_found) && $stable(rsp_position))
      else $error("response changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_EMPTY || rsp_status == STAT_FULL)
         |-> rsp_data == '0 && !rsp_found && rsp_position == '0)
      else $error("error status with payload");

   a_no_hit_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("position without a match");

   // request side blocks only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with output free");

endmodule

bind fifo_queue_with_search_core fqs_checker u_fqs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_data     (rsp_data),
   .rsp_position (rsp_position),
   .rsp_found    (rsp_found),
   .rsp_status   (rsp_status)
);
